/* design/route_table_with_aging_core_defines.svh */
// ----------------------------------------------------------------------------
// Route table assertion macros
// Shared assertion wrappers for the route table core; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ROUTE_TABLE_WITH_AGING_CORE_DEFINES_SVH
`define ROUTE_TABLE_WITH_AGING_CORE_DEFINES_SVH

`ifndef SYNTH
// Checked on every edge outside reset.
`define RTWA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Checked on every edge, reset included.
`define RTWA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RTWA_ASSERT(lbl, prop, msg)
`define RTWA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* design/rtwa_pkg.sv */
// ----------------------------------------------------------------------------
// Route table package
// Types, codes and field layout shared by the route table core.
// ----------------------------------------------------------------------------
package rtwa_pkg;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DECIDE
	} st_t;

	// Result status codes.
	localparam logic [2:0] STAT_ADDED   = 3'd0;
	localparam logic [2:0] STAT_UPDATED = 3'd1;
	localparam logic [2:0] STAT_SAME    = 3'd2;
	localparam logic [2:0] STAT_OWN     = 3'd3;
	localparam logic [2:0] STAT_BAD_ITF = 3'd4;
	localparam logic [2:0] STAT_FULL    = 3'd5;

	// Configuration register indexes.
	localparam logic [1:0] REG_LIFETIME = 2'd0;
	localparam logic [1:0] REG_OWN_ADDR = 2'd1;
	localparam logic [1:0] REG_ITF_MASK = 2'd2;

	localparam logic [31:0] LIFETIME_RESET = 32'd1000000;
	localparam logic [4:0]  AGED_MAX       = 5'd31;

	// Input beat layout, lowest bit first.
	localparam int IN_NOW_LSB   = 0;
	localparam int IN_SRC_LSB   = 48;
	localparam int IN_TGT_LSB   = 80;
	localparam int IN_MAC_LSB   = 112;
	localparam int IN_ITF_LSB   = 160;
	localparam int IN_HOPS_LSB  = 164;
	localparam int IN_FORCE_LSB = 172;
	localparam int IN_WIDTH     = 176;
	localparam int OUT_WIDTH    = 72;

	// One table entry as held in the slot memory.
	typedef struct packed {
		logic [47:0] stamp;
		logic [7:0]  hops;
		logic [3:0]  itf;
		logic [47:0] next_mac;
		logic [31:0] dest;
	} entry_t;

endpackage

/* design/rtwa_ram.sv */
// ----------------------------------------------------------------------------
// Route table RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rtwa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/route_table_with_aging_core.sv */
// ----------------------------------------------------------------------------
// Route table with aging
// Distance-vector route table: ages entries out, learns the reverse route to
// each packet's source and reports the route to its destination.
// ----------------------------------------------------------------------------
//
// Channel      Direction  Handshake                 Content
// s_axis_*     in         tvalid / tready           one routing header and time
// m_axis_*     out        tvalid / tready           status and route to target
// cfg_*        in         cfg_valid / cfg_ready     register index and data
//
// An item goes through capture of the beat, a walk of the slot memory through
// its single registered read port, and a decision and write step; the next
// beat is accepted only once the sequencer is back in its idle state.
// The walk is set by that one read port and the single age comparator that
// every slot passes through in turn.
// Reset clears the slot valid bits at once; no clearing pass is needed, and
// entry contents are never used before they are written.
// The finished result sits in an output register, so a new beat is taken
// while it waits; the decision step waits only if that register is still full.
//
module route_table_with_aging_core #(
	parameter int TABLE_ENTRIES   = 16,
	parameter int INTERFACE_COUNT = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,

	// Fields from bit 0 up: now_us[47:0], source_address[79:48],
	// target_address[111:80], sender_mac[159:112], arrival_interface[163:160],
	// hop_count[171:164], force_rediscovery[172], zero fill[175:173].
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [rtwa_pkg::IN_WIDTH-1:0]  s_axis_tdata,

	// Fields from bit 0 up: status[2:0], aged_out_count[7:3], target_found[8],
	// target_hops[16:9], target_next_mac[64:17], target_interface[68:65],
	// zero fill[71:69].
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [rtwa_pkg::OUT_WIDTH-1:0] m_axis_tdata,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [31:0]                    cfg_data
);

	import rtwa_pkg::*;

	`include "route_table_with_aging_core_defines.svh"

	localparam int IdxW = $clog2(TABLE_ENTRIES);
	localparam int PtrW = IdxW + 1;

	// Configuration registers.
	logic [31:0] lifetime_q;
	logic [31:0] own_addr_q;
	logic [15:0] itf_mask_q;

	// Captured input beat.
	logic [47:0] now_q;
	logic [31:0] src_q;
	logic [31:0] tgt_q;
	logic [47:0] mac_q;
	logic [3:0]  itf_q;
	logic [7:0]  hops_q;
	logic        force_q;
	logic        own_q;

	// Sequencer and walk state.
	st_t                    st_q, st_d;
	logic [PtrW-1:0]        ptr_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [4:0]             aged_q;
	logic                   force_done_q;
	logic                   src_found_q;
	logic [IdxW-1:0]        src_idx_q;
	logic [7:0]             src_hops_q;
	logic [47:0]            src_mac_q;
	logic [3:0]             src_itf_q;
	logic                   free_found_q;
	logic [IdxW-1:0]        free_idx_q;
	logic                   tgt_found_q;
	logic [7:0]             tgt_hops_q;
	logic [47:0]            tgt_mac_q;
	logic [3:0]             tgt_itf_q;

	// Output register.
	logic        m_valid_q;
	logic [2:0]  o_status_q;
	logic [4:0]  o_aged_q;
	logic        o_found_q;
	logic [7:0]  o_hops_q;
	logic [47:0] o_mac_q;
	logic [3:0]  o_itf_q;

	// Sequencer controls.
	logic in_fire;
	logic walk_last;
	logic eval_en;
	logic decide_fire;

	// Slot memory.
	logic            ram_we;
	logic [IdxW-1:0] ram_waddr;
	entry_t          ram_wdata;
	logic [IdxW-1:0] ram_raddr;
	entry_t          rd_entry;

	// Per-slot evaluation.
	logic [IdxW-1:0] eidx;
	logic            e_vld;
	logic [47:0]     e_age;
	logic            e_stale;
	logic            e_fhit;
	logic            e_survive;
	logic            e_src_hit;
	logic            e_tgt_hit;
	logic            e_free_hit;

	// Decision.
	logic        itf_ok;
	logic        better;
	logic [2:0]  dec_status;
	logic        dec_write;
	logic [IdxW-1:0] dec_idx;

	// ------------------------------------------------------------------
	// Configuration port: always ready. The registers are meant to change
	// only while no beat is in flight.
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= LIFETIME_RESET;
			own_addr_q <= '0;
			itf_mask_q <= '1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LIFETIME: lifetime_q <= cfg_data;
				REG_OWN_ADDR: own_addr_q <= cfg_data;
				REG_ITF_MASK: itf_mask_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	assign walk_last = (ptr_q == PtrW'(TABLE_ENTRIES));

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:   if (s_axis_tvalid) st_d = ST_WALK;
			ST_WALK:   if (walk_last) st_d = ST_DECIDE;
			ST_DECIDE: if (!m_valid_q || m_axis_tready) st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		eval_en       = 1'b0;
		decide_fire   = 1'b0;
		unique case (st_q)
			ST_IDLE:   s_axis_tready = 1'b1;
			ST_WALK:   eval_en = (ptr_q != '0);
			ST_DECIDE: decide_fire = !m_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	assign in_fire = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// The captured beat needs no reset: it is only used after an acceptance.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			now_q   <= s_axis_tdata[IN_NOW_LSB +: 48];
			src_q   <= s_axis_tdata[IN_SRC_LSB +: 32];
			tgt_q   <= s_axis_tdata[IN_TGT_LSB +: 32];
			mac_q   <= s_axis_tdata[IN_MAC_LSB +: 48];
			itf_q   <= s_axis_tdata[IN_ITF_LSB +: 4];
			hops_q  <= s_axis_tdata[IN_HOPS_LSB +: 8];
			force_q <= s_axis_tdata[IN_FORCE_LSB];
			own_q   <= (s_axis_tdata[IN_SRC_LSB +: 32] == own_addr_q);
		end
	end

	// ------------------------------------------------------------------
	// Slot memory. The walk issues the read of slot ptr while it judges
	// slot ptr - 1, whose data has just come out of the read register.
	// ------------------------------------------------------------------
	assign ram_raddr = walk_last ? '0 : ptr_q[IdxW-1:0];

	rtwa_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_entry)
	);

	// ------------------------------------------------------------------
	// Slot judgement: one age comparator shared by every slot in turn.
	// A slot is dropped when stale; the first surviving slot that holds the
	// target is dropped too when rediscovery is forced. Own packets only look.
	// ------------------------------------------------------------------
	assign eidx       = IdxW'(ptr_q - PtrW'(1));
	assign e_vld      = valid_q[eidx];
	assign e_age      = now_q - rd_entry.stamp;
	assign e_stale    = !own_q && e_vld && (e_age > {16'b0, lifetime_q});
	assign e_fhit     = !own_q && force_q && !force_done_q && e_vld && !e_stale &&
	                    (rd_entry.dest == tgt_q);
	assign e_survive  = e_vld && !e_stale && !e_fhit;
	assign e_src_hit  = e_survive && !src_found_q && (rd_entry.dest == src_q);
	assign e_tgt_hit  = e_survive && !tgt_found_q && (rd_entry.dest == tgt_q);
	assign e_free_hit = !e_survive && !free_found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			aged_q       <= '0;
			force_done_q <= 1'b0;
			src_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			tgt_found_q  <= 1'b0;
		end else if (in_fire) begin
			ptr_q        <= '0;
			aged_q       <= '0;
			force_done_q <= 1'b0;
			src_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			tgt_found_q  <= 1'b0;
		end else if (st_q == ST_WALK) begin
			ptr_q <= ptr_q + PtrW'(1);
			if (eval_en) begin
				if (e_stale && aged_q != AGED_MAX) begin
					aged_q <= aged_q + 5'd1;
				end
				if (e_fhit) begin
					force_done_q <= 1'b1;
				end
				if (e_src_hit) begin
					src_found_q <= 1'b1;
				end
				if (e_free_hit) begin
					free_found_q <= 1'b1;
				end
				if (e_tgt_hit) begin
					tgt_found_q <= 1'b1;
				end
			end
		end
	end

	// Fields of the matched slots are only read with their found flags set.
	always_ff @(posedge clk) begin
		if (eval_en) begin
			if (e_src_hit) begin
				src_idx_q  <= eidx;
				src_hops_q <= rd_entry.hops;
				src_mac_q  <= rd_entry.next_mac;
				src_itf_q  <= rd_entry.itf;
			end
			if (e_free_hit) begin
				free_idx_q <= eidx;
			end
			if (e_tgt_hit) begin
				tgt_hops_q <= rd_entry.hops;
				tgt_mac_q  <= rd_entry.next_mac;
				tgt_itf_q  <= rd_entry.itf;
			end
		end
	end

	// ------------------------------------------------------------------
	// Decision: add, refresh or leave the reverse route to the source.
	// ------------------------------------------------------------------
	assign itf_ok = (32'(itf_q) < INTERFACE_COUNT) && itf_mask_q[itf_q];
	assign better = (hops_q < src_hops_q) ||
	                ((hops_q == src_hops_q) && ((mac_q != src_mac_q) || (itf_q != src_itf_q)));

	always_comb begin
		dec_write  = 1'b0;
		dec_idx    = free_idx_q;
		dec_status = STAT_SAME;
		if (own_q) begin
			dec_status = STAT_OWN;
		end else if (!itf_ok) begin
			dec_status = STAT_BAD_ITF;
		end else if (src_found_q) begin
			dec_idx = src_idx_q;
			if (better) begin
				dec_write  = 1'b1;
				dec_status = STAT_UPDATED;
			end
		end else if (free_found_q) begin
			dec_write  = 1'b1;
			dec_status = STAT_ADDED;
		end else begin
			dec_status = STAT_FULL;
		end
	end

	assign ram_we    = decide_fire && dec_write;
	assign ram_waddr = dec_idx;
	assign ram_wdata = '{stamp: now_q, hops: hops_q, itf: itf_q, next_mac: mac_q, dest: src_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (eval_en && !e_survive) begin
			valid_q[eidx] <= 1'b0;
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Result register. When the source is also the target, a written entry
	// is the target route; otherwise the write never touches it.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (decide_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (decide_fire) begin
			o_status_q <= dec_status;
			o_aged_q   <= aged_q;
			if (dec_write && src_q == tgt_q) begin
				o_found_q <= 1'b1;
				o_hops_q  <= hops_q;
				o_mac_q   <= mac_q;
				o_itf_q   <= itf_q;
			end else if (tgt_found_q) begin
				o_found_q <= 1'b1;
				o_hops_q  <= tgt_hops_q;
				o_mac_q   <= tgt_mac_q;
				o_itf_q   <= tgt_itf_q;
			end else begin
				o_found_q <= 1'b0;
				o_hops_q  <= '0;
				o_mac_q   <= '0;
				o_itf_q   <= '0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {3'b000, o_itf_q, o_mac_q, o_hops_q, o_found_q, o_aged_q, o_status_q};

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`RTWA_ASSERT(a_accept_starts_walk, in_fire |=> (st_q == ST_WALK && ptr_q == '0), "accepted beat did not start a walk")
	`RTWA_ASSERT(a_write_only_deciding, ram_we |-> (st_q == ST_DECIDE && !own_q), "slot memory written outside a decision")
	`RTWA_ASSERT(a_own_no_aging, (m_axis_tvalid && o_status_q == STAT_OWN) |-> (o_aged_q == '0), "own packet reported aged entries")
	`RTWA_ASSERT(a_no_route_zero, (m_axis_tvalid && !o_found_q) |-> (o_hops_q == '0 && o_mac_q == '0 && o_itf_q == '0), "missing route carries nonzero fields")
	`RTWA_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !m_axis_tvalid, "result valid straight after reset")

endmodule

/* tb/tb_route_table_with_aging_core.sv */
// ----------------------------------------------------------------------------
// Route table with aging: block-level testbench
// Feeds routing headers through the stream port, keeps a shadow of the route
// table, and checks every reply beat against it field by field while the
// register settings, the time base and the handshake pressure are varied.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_route_table_with_aging_core;
	import rtwa_pkg::*;

	localparam int DEPTH     = 16;
	localparam int ITF_COUNT = 16;
	localparam int POOL_SIZE = 24;
	// Index 3 has no register behind it; a write there must change nothing.
	localparam logic [1:0] REG_SPARE = 2'd3;
	// Time for one header through the block; the receiver's stalls come on top.
	localparam int ITEM_CYCLES    = DEPTH + 3;
	localparam int WATCHDOG_LIMIT = 2000;

	// One received routing header as the testbench sees it.
	typedef struct packed {
		bit [47:0] now_us;
		bit [31:0] source;
		bit [31:0] target;
		bit [47:0] sender_mac;
		bit [3:0]  arrival_itf;
		bit [7:0]  hop_count;
		bit        rediscover;
	} header_t;

	// One reply beat: the status and the route towards the header's target.
	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  aged;
		logic        found;
		logic [7:0]  hops;
		logic [47:0] next_mac;
		logic [3:0]  itf;
	} reply_t;

	// Shadow copy of the route table. Every accepted header is applied to it
	// straight away, and the reply that the block owes is queued.
	class route_table_shadow;
		bit          live [DEPTH];
		bit [31:0]   dest [DEPTH];
		bit [47:0]   mac [DEPTH];
		bit [3:0]    itf [DEPTH];
		bit [7:0]    hops [DEPTH];
		bit [47:0]   stamp [DEPTH];
		bit [31:0]   lifetime = LIFETIME_RESET;
		bit [31:0]   own_addr = '0;
		bit [15:0]   itf_mask = 16'hFFFF;
		reply_t      replies_due [$];
		int          mismatches;
		int          headers_taken;
		int          replies_checked;
		int          drops_total;
		int          found_total;
		int          status_tally [8];

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_LIFETIME: lifetime = val;
				REG_OWN_ADDR: own_addr = val;
				REG_ITF_MASK: itf_mask = val[15:0];
				default: ;
			endcase
		endfunction

		function int find_route(bit [31:0] addr);
			for (int i = 0; i < DEPTH; i++)
				if (live[i] && dest[i] == addr)
					return i;
			return -1;
		endfunction

		function int pending();
			return replies_due.size();
		endfunction

		function void note_header(header_t h);
			reply_t    r;
			bit [47:0] age;
			int        hit;
			int        slot;
			int        dropped;
			r = '0;
			dropped = 0;
			slot = -1;
			if (h.source == own_addr) begin
				// Our own packet coming back: the table is left alone.
				r.status = STAT_OWN;
			end else begin
				// Age is taken modulo 2^48, so a stamp ahead of now looks ancient.
				for (int i = 0; i < DEPTH; i++) begin
					age = h.now_us - stamp[i];
					if (live[i] && age > {16'd0, lifetime}) begin
						live[i] = 1'b0;
						dropped++;
					end
				end
				if (h.rediscover) begin
					hit = find_route(h.target);
					if (hit >= 0)
						live[hit] = 1'b0;
				end
				if (int'(h.arrival_itf) >= ITF_COUNT || !itf_mask[h.arrival_itf]) begin
					r.status = STAT_BAD_ITF;
				end else begin
					hit = find_route(h.source);
					if (hit < 0) begin
						for (int i = DEPTH - 1; i >= 0; i--)
							if (!live[i])
								slot = i;
						r.status = (slot < 0) ? STAT_FULL : STAT_ADDED;
					end else if (h.hop_count < hops[hit] ||
					             (h.hop_count == hops[hit] &&
					              (h.sender_mac != mac[hit] || h.arrival_itf != itf[hit]))) begin
						slot = hit;
						r.status = STAT_UPDATED;
					end else begin
						// An unchanged route keeps its old stamp.
						r.status = STAT_SAME;
					end
				end
				if (slot >= 0) begin
					live[slot]  = 1'b1;
					dest[slot]  = h.source;
					mac[slot]   = h.sender_mac;
					itf[slot]   = h.arrival_itf;
					hops[slot]  = h.hop_count;
					stamp[slot] = h.now_us;
				end
			end
			r.aged = (dropped > int'(AGED_MAX)) ? AGED_MAX : dropped[4:0];
			hit = find_route(h.target);
			if (hit >= 0) begin
				r.found    = 1'b1;
				r.hops     = hops[hit];
				r.next_mac = mac[hit];
				r.itf      = itf[hit];
				found_total++;
			end
			status_tally[r.status]++;
			drops_total += dropped;
			headers_taken++;
			replies_due.push_back(r);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("%0t mismatch on reply %0d, %s: got %h, want %h",
			         $time, replies_checked, what, got, want);
			mismatches++;
		endtask

		task check_result(logic [OUT_WIDTH-1:0] d);
			reply_t got;
			reply_t want;
			got.status   = d[2:0];
			got.aged     = d[7:3];
			got.found    = d[8];
			got.hops     = d[16:9];
			got.next_mac = d[64:17];
			got.itf      = d[68:65];
			if (replies_due.size() == 0) begin
				report("reply with nothing due", d[63:0], '0);
				return;
			end
			want = replies_due.pop_front();
			if (got.status !== want.status)
				report("status", 64'(got.status), 64'(want.status));
			if (got.aged !== want.aged)
				report("aged out count", 64'(got.aged), 64'(want.aged));
			if (got.found !== want.found)
				report("target found", 64'(got.found), 64'(want.found));
			if (got.hops !== want.hops)
				report("target hops", 64'(got.hops), 64'(want.hops));
			if (got.next_mac !== want.next_mac)
				report("target next mac", 64'(got.next_mac), 64'(want.next_mac));
			if (got.itf !== want.itf)
				report("target interface", 64'(got.itf), 64'(want.itf));
			replies_checked++;
		endtask
	endclass

	// Every input of the block starts at a known value.
	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_WIDTH-1:0]   s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_WIDTH-1:0]  m_axis_tdata;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [1:0]            cfg_index     = '0;
	logic [31:0]           cfg_data      = '0;

	route_table_shadow shadow = new();

	// Percentage of cycles in which the sender holds back and the receiver stalls.
	int          src_idle_pct  = 8;
	int          sink_idle_pct = 52;
	// Running time base for the well-formed headers; wraps at 2^48 like the block.
	bit [47:0]   now_track;
	int          regs_written;
	int          quiet_cycles;

	route_table_with_aging_core #(
		.TABLE_ENTRIES   (DEPTH),
		.INTERFACE_COUNT (ITF_COUNT)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// The receiver decides afresh at every falling edge whether to stall.
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// Reply beats are taken at the rising edge, before the block's own update.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			shadow.check_result(m_axis_tdata);
	end

	// Watchdog: a long run of cycles in which no beat moves on any channel
	// means the block has hung.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic header_t make_header(bit [47:0] now_us, bit [31:0] source,
	                                        bit [31:0] target, bit [47:0] sender_mac,
	                                        bit [3:0] arrival_itf, bit [7:0] hop_count,
	                                        bit rediscover);
		header_t h;
		h = '{now_us, source, target, sender_mac, arrival_itf, hop_count, rediscover};
		return h;
	endfunction

	// Offers one header beat. Called and returning at a falling edge; tvalid
	// is left high so that a following beat can go out without a gap.
	task automatic send_header(input header_t h);
		logic [IN_WIDTH-1:0] beat;
		beat = '0;
		beat[IN_NOW_LSB +: 48]  = h.now_us;
		beat[IN_SRC_LSB +: 32]  = h.source;
		beat[IN_TGT_LSB +: 32]  = h.target;
		beat[IN_MAC_LSB +: 48]  = h.sender_mac;
		beat[IN_ITF_LSB +: 4]   = h.arrival_itf;
		beat[IN_HOPS_LSB +: 8]  = h.hop_count;
		beat[IN_FORCE_LSB]      = h.rediscover;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= beat;
		do @(posedge clk); while (!s_axis_tready);
		shadow.note_header(h);
		@(negedge clk);
	endtask

	// Writes one register and leaves cfg_valid high; the caller lowers it
	// once the whole batch of writes has gone through.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		shadow.set_reg(idx, val);
		regs_written++;
		@(negedge clk);
	endtask

	// One stretch of random traffic under one register setting. Most headers
	// come from a small pool of sources and destinations with small hop counts
	// and a handful of next-hop MACs, so routes are learnt, refreshed, aged and
	// the table fills up; the rest are fully random beats.
	task automatic run_phase(input logic [31:0] life, input logic [31:0] own,
	                         input logic [15:0] mask, input int step, input int count,
	                         input bit poke_spare);
		logic [31:0] pool [POOL_SIZE];
		logic [47:0] macs [4];
		logic [63:0] wide;
		header_t     h;
		// Registers change only with the block idle and every reply back.
		s_axis_tvalid <= 1'b0;
		while (shadow.pending() != 0)
			@(negedge clk);
		write_reg(REG_LIFETIME, life);
		write_reg(REG_OWN_ADDR, own);
		write_reg(REG_ITF_MASK, {16'd0, mask});
		if (poke_spare)
			write_reg(REG_SPARE, $urandom);
		cfg_valid <= 1'b0;
		// The node's own address sits in the pool, so own packets turn up.
		pool[0] = own;
		for (int i = 1; i < POOL_SIZE; i++)
			pool[i] = $urandom;
		for (int i = 0; i < 4; i++) begin
			wide = {$urandom, $urandom};
			macs[i] = wide[47:0];
		end
		repeat (count) begin
			if ($urandom_range(99) < 85) begin
				now_track = now_track + 48'($urandom_range(step));
				// Now and then a jump just past the lifetime.
				if ($urandom_range(99) < 3)
					now_track = now_track + life + 48'd1;
				h.now_us      = now_track;
				h.source      = pool[$urandom_range(POOL_SIZE - 1)];
				h.target      = pool[$urandom_range(POOL_SIZE - 1)];
				h.sender_mac  = macs[$urandom_range(3)];
				h.arrival_itf = 4'($urandom_range(ITF_COUNT - 1));
				h.hop_count   = 8'($urandom_range(7));
				h.rediscover  = ($urandom_range(99) < 10);
			end else begin
				wide          = {$urandom, $urandom};
				h.now_us      = wide[47:0];
				h.source      = $urandom_range(1) ? $urandom : pool[$urandom_range(3)];
				h.target      = $urandom_range(1) ? $urandom : pool[$urandom_range(3)];
				wide          = {$urandom, $urandom};
				h.sender_mac  = wide[47:0];
				h.arrival_itf = 4'($urandom_range(15));
				h.hop_count   = 8'($urandom_range(255));
				h.rediscover  = 1'($urandom_range(1));
			end
			send_header(h);
		end
	endtask

	initial begin
		logic [31:0] addr_a;
		logic [31:0] addr_b;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed headers under the reset settings: lifetime one second,
		// own address zero, every interface present.
		addr_a = 32'h0A00_0001;
		addr_b = 32'h0A00_0002;
		// Source equal to the own address: ignored.
		send_header(make_header(48'd0, 32'd0, addr_a, 48'd1, 4'd0, 8'd0, 1'b0));
		// A new route, learnt with the widest field values, then the same path
		// again, which leaves it (and its stamp) untouched.
		send_header(make_header(48'd1000, addr_a, addr_a, '1, 4'd15, 8'd255, 1'b0));
		send_header(make_header(48'd1100, addr_a, addr_a, '1, 4'd15, 8'd255, 1'b0));
		// Equal hops through another MAC, then through another interface.
		send_header(make_header(48'd1200, addr_a, addr_a, 48'd0, 4'd15, 8'd255, 1'b0));
		send_header(make_header(48'd1300, addr_a, addr_a, 48'd0, 4'd0, 8'd255, 1'b0));
		// Fewer hops replace the route; more hops do not.
		send_header(make_header(48'd1400, addr_a, addr_a, 48'd0, 4'd0, 8'd0, 1'b0));
		send_header(make_header(48'd1500, addr_a, addr_a, 48'd0, 4'd0, 8'd1, 1'b0));
		// Fifteen more sources fill the table, each into the lowest free slot.
		for (int k = 1; k < DEPTH; k++)
			send_header(make_header(48'(1500 + k), 32'hFFFF_FFF0 + k, addr_a, 48'(k),
			                        4'(k), 8'(k), 1'b0));
		// One source too many: the table is full.
		send_header(make_header(48'd1600, addr_b, 32'hFFFF_FFFF, 48'd7, 4'd2, 8'd3, 1'b0));
		// Forced rediscovery drops the route to the target.
		send_header(make_header(48'd1700, 32'hFFFF_FFF1, addr_a, 48'd1, 4'd1, 8'd1, 1'b1));
		// A jump well past the lifetime ages every entry out.
		send_header(make_header(48'd2000000, addr_b, addr_b, 48'd9, 4'd3, 8'd2, 1'b0));
		// Time running backwards: the newest stamp now lies ahead and goes too.
		send_header(make_header(48'd0, addr_a, addr_b, 48'd9, 4'd3, 8'd2, 1'b0));

		// Random traffic: first a slow receiver, then a slow sender, then
		// neither holds back.
		now_track = 48'd5000;
		run_phase(32'd2000, $urandom, 16'hFFFF, 400, 200, 1'b0);
		run_phase(32'd0, 32'hFFFF_FFFF, 16'h5A5A, 1, 200, 1'b1);
		src_idle_pct  = 52;
		sink_idle_pct = 8;
		// Start just below the wrap of the time base.
		now_track = 48'hFFFF_FFC0_0000;
		run_phase(32'hFFFF_FFFF, 32'd0, 16'hFFFE, 1 << 20, 200, 1'b0);
		run_phase(LIFETIME_RESET, $urandom, 16'h7FFF, 20000, 200, 1'b1);
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		run_phase(32'd50000, $urandom, 16'hFFFF, 10000, 200, 1'b0);
		// No interface present: every header but the node's own is refused, though aging goes on.
		run_phase(32'd0, 32'd0, 16'h0000, 1, 25, 1'b0);
		run_phase(32'd5000, $urandom, 16'h8001, 1000, 200, 1'b0);

		// Drain, then let the block settle before the summary.
		s_axis_tvalid <= 1'b0;
		while (shadow.pending() != 0)
			@(negedge clk);
		repeat (2 * ITEM_CYCLES) @(negedge clk);

		$display("Covered %0d headers over %0d register writes: %0d added, %0d updated,",
		         shadow.headers_taken, regs_written, shadow.status_tally[STAT_ADDED],
		         shadow.status_tally[STAT_UPDATED]);
		$display("  %0d unchanged, %0d own, %0d bad interface, %0d full, %0d aged out, %0d hits.",
		         shadow.status_tally[STAT_SAME], shadow.status_tally[STAT_OWN],
		         shadow.status_tally[STAT_BAD_ITF], shadow.status_tally[STAT_FULL],
		         shadow.drops_total, shadow.found_total);
		if (shadow.mismatches == 0 && shadow.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/rtwa_pkg.sv
design/rtwa_ram.sv
design/route_table_with_aging_core.sv
tb/tb_route_table_with_aging_core.sv
